>>> rtl/core/ubx_frame_builder_macros.svh
// ----------------------------------------------------------------------------
// UBX frame builder assertion macros
// Shared concurrent assertion wrappers, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_BUILDER_MACROS_SVH
`define UBX_FRAME_BUILDER_MACROS_SVH

// Checked outside reset only
`define UBXFB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define UBXFB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/ubxfb_pkg.sv
// ----------------------------------------------------------------------------
// UBX frame builder package
// Shared types, codes and constants of the frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ubxfb_pkg;

   // Default frame buffer limit in bytes (header, payload and checksum)
   localparam int FRAME_BYTES_DEF = 128;

   // Frame framing overhead: two sync, class, id, two length, two checksum
   localparam int FRAME_OVERHEAD = 8;

   // Sync bytes
   localparam logic [7:0] SYNC_ONE = 8'hB5;
   localparam logic [7:0] SYNC_TWO = 8'h62;

   // Request operations
   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERSIZE = 2'd1;
   localparam logic [1:0] ERR_NO_FRAME = 2'd2;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Up to eight responses per request
   localparam int IDX_W = 3;

   typedef enum logic [1:0] {
      JOB_HEADER,
      JOB_PAYLOAD,
      JOB_ERR_SIZE,
      JOB_ERR_FRAME
   } job_kind_type;

   typedef struct packed {
      logic        operation;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_len;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_frame;
      logic [1:0] error_code;
      logic       last_of_run;
   } rsp_type;

   // One classified request, ready for serialization
   typedef struct packed {
      job_kind_type kind;
      logic         with_cksum;
      logic [7:0]   msg_class;
      logic [7:0]   msg_id;
      logic [15:0]  payload_len;
      logic [7:0]   payload_byte;
      logic [7:0]   sum_a;
      logic [7:0]   sum_b;
   } job_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

>>> rtl/core/ubxfb_front.sv
// ----------------------------------------------------------------------------
// UBX frame builder front end
// Accepts requests, tracks the open frame and the Fletcher sums, and
// pushes one classified job per request into the job queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubxfb_front #(
   parameter int FRAME_BYTES = ubxfb_pkg::FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ubxfb_pkg::req_type        req_payload,
   input  ubxfb_pkg::queue_stat_type q_stat,
   output logic                      push,
   output ubxfb_pkg::job_type        push_job
);

   localparam int MAX_LEN = FRAME_BYTES - ubxfb_pkg::FRAME_OVERHEAD;
   localparam int LEFT_W  = $clog2(MAX_LEN + 1);

   logic [7:0]        sum_a_ff, sum_a_in;
   logic [7:0]        sum_b_ff, sum_b_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic              open_ff, open_in;

   logic [7:0] a1, a2, a3, a4;
   logic [7:0] b2, b3, b4;
   logic [7:0] pa, pb;
   logic       oversize;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   // Header sums over class, id, length low and high
   always_comb begin
      a1 = req_payload.msg_class;
      a2 = a1 + req_payload.msg_id;
      b2 = a1 + a2;
      a3 = a2 + req_payload.payload_len[7:0];
      b3 = b2 + a3;
      a4 = a3 + req_payload.payload_len[15:8];
      b4 = b3 + a4;
      pa = sum_a_ff + req_payload.payload_byte;
      pb = sum_b_ff + pa;
      oversize = {1'b0, req_payload.payload_len} > 17'(MAX_LEN);
   end

   // Classify the request and work out the next state
   always_comb begin
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      left_in  = left_ff;
      open_in  = open_ff;
      push_job.kind         = ubxfb_pkg::JOB_ERR_FRAME;
      push_job.with_cksum   = 1'b0;
      push_job.msg_class    = req_payload.msg_class;
      push_job.msg_id       = req_payload.msg_id;
      push_job.payload_len  = req_payload.payload_len;
      push_job.payload_byte = req_payload.payload_byte;
      push_job.sum_a        = a4;
      push_job.sum_b        = b4;
      if (req_payload.operation == ubxfb_pkg::OP_START) begin
         open_in = 1'b0;
         left_in = '0;
         if (oversize) begin
            push_job.kind = ubxfb_pkg::JOB_ERR_SIZE;
         end else begin
            push_job.kind = ubxfb_pkg::JOB_HEADER;
            sum_a_in = a4;
            sum_b_in = b4;
            if (req_payload.payload_len == 16'd0) begin
               push_job.with_cksum = 1'b1;
            end else begin
               left_in = req_payload.payload_len[LEFT_W-1:0];
               open_in = 1'b1;
            end
         end
      end else if (open_ff) begin
         push_job.kind  = ubxfb_pkg::JOB_PAYLOAD;
         push_job.sum_a = pa;
         push_job.sum_b = pb;
         sum_a_in = pa;
         sum_b_in = pb;
         if (left_ff == LEFT_W'(1)) begin
            push_job.with_cksum = 1'b1;
            left_in = '0;
            open_in = 1'b0;
         end else begin
            left_in = left_ff - LEFT_W'(1);
         end
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         left_ff  <= '0;
         open_ff  <= 1'b0;
      end else if (push) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         left_ff  <= left_in;
         open_ff  <= open_in;
      end
   end

endmodule

>>> rtl/core/ubxfb_queue.sv
// ----------------------------------------------------------------------------
// UBX frame builder job queue
// Small register queue that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubxfb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ubxfb_pkg::job_type        push_job,
   input  logic                      pop,
   output ubxfb_pkg::job_type        head_job,
   output ubxfb_pkg::queue_stat_type q_stat
);

   localparam int PW = ubxfb_pkg::QPTR_W;

   ubxfb_pkg::job_type mem_ff [ubxfb_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign head_job     = mem_ff[rd_ptr_ff];
   assign q_stat.full  = count_ff == (PW+1)'(ubxfb_pkg::QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/ubxfb_back.sv
// ----------------------------------------------------------------------------
// UBX frame builder serializer
// Walks the job at the queue head one byte per cycle, while the response is
// not stalled, into the response register, and pops the job with its last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubxfb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ubxfb_pkg::job_type        head_job,
   input  ubxfb_pkg::queue_stat_type q_stat,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ubxfb_pkg::rsp_type        rsp_payload
);

   localparam int IW = ubxfb_pkg::IDX_W;

   logic [IW-1:0]      idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ubxfb_pkg::rsp_type rsp_ff, rsp_in;
   logic [IW-1:0]      last_idx;
   logic               load;
   logic               is_last;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Output register takes a new byte when empty or being drained
   assign load    = !q_stat.empty && (!rsp_valid_ff || !rsp_stall);
   assign is_last = idx_ff == last_idx;
   assign pop     = load && is_last;

   // Select the byte at the current position of the job
   always_comb begin
      last_idx = '0;
      rsp_in   = '0;
      case (head_job.kind)
         ubxfb_pkg::JOB_HEADER: begin
            last_idx = head_job.with_cksum ? IW'(7) : IW'(5);
            case (idx_ff)
               IW'(0):  rsp_in.out_byte = ubxfb_pkg::SYNC_ONE;
               IW'(1):  rsp_in.out_byte = ubxfb_pkg::SYNC_TWO;
               IW'(2):  rsp_in.out_byte = head_job.msg_class;
               IW'(3):  rsp_in.out_byte = head_job.msg_id;
               IW'(4):  rsp_in.out_byte = head_job.payload_len[7:0];
               IW'(5):  rsp_in.out_byte = head_job.payload_len[15:8];
               IW'(6):  rsp_in.out_byte = head_job.sum_a;
               default: rsp_in.out_byte = head_job.sum_b;
            endcase
         end
         ubxfb_pkg::JOB_PAYLOAD: begin
            last_idx = head_job.with_cksum ? IW'(2) : IW'(0);
            case (idx_ff)
               IW'(0):  rsp_in.out_byte = head_job.payload_byte;
               IW'(1):  rsp_in.out_byte = head_job.sum_a;
               default: rsp_in.out_byte = head_job.sum_b;
            endcase
         end
         ubxfb_pkg::JOB_ERR_SIZE: begin
            rsp_in.error_code = ubxfb_pkg::ERR_OVERSIZE;
         end
         default: begin
            rsp_in.error_code = ubxfb_pkg::ERR_NO_FRAME;
         end
      endcase
      rsp_in.end_of_frame = head_job.with_cksum && is_last;
      rsp_in.last_of_run  = is_last;
   end

   // Position and valid update
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = is_last ? '0 : idx_ff + IW'(1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> rtl/core/ubx_frame_builder.sv
// ----------------------------------------------------------------------------
// UBX frame builder
// Builds UBX binary frames with the 8-bit Fletcher checksum, byte by byte.
// ----------------------------------------------------------------------------
// A start request yields 6 response bytes (sync, class, id, length) or 8 when
// the length is zero; a payload request yields 1 byte, or 3 on the frame's
// final payload byte; error requests yield 1. Responses leave at one byte per
// cycle unless the response channel stalls, so the serializer sets the
// sustained rate. The front end takes one request per cycle into a 4-entry
// job queue and stalls only when that queue is full; requests and responses
// overlap freely.
`timescale 1ns / 1ps

module ubx_frame_builder #(
   parameter int FRAME_BYTES = ubxfb_pkg::FRAME_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ubxfb_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ubxfb_pkg::rsp_type rsp_payload
);

   logic                      push;
   logic                      pop;
   ubxfb_pkg::job_type        push_job;
   ubxfb_pkg::job_type        head_job;
   ubxfb_pkg::queue_stat_type q_stat;

   ubxfb_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .push_job    (push_job)
   );

   ubxfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   ubxfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_stat      (q_stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/core/ubxfb_checker.sv
// ----------------------------------------------------------------------------
// UBX frame builder port checker
// Watches the response channel of the frame builder over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ubx_frame_builder_macros.svh"

module ubxfb_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ubxfb_pkg::rsp_type rsp_payload
);

   // A stalled response holds
   `UBXFB_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled response changed")

   // Errors are single zero-byte responses
   `UBXFB_ASSERT(a_err_shape, rsp_valid && rsp_payload.error_code != ubxfb_pkg::ERR_NONE |-> rsp_payload.last_of_run && rsp_payload.out_byte == 8'd0 && !rsp_payload.end_of_frame, "malformed error response")

   // Frame end closes the request's run
   `UBXFB_ASSERT(a_eof_last, rsp_valid && rsp_payload.end_of_frame |-> rsp_payload.last_of_run, "end of frame before end of run")

   // Nothing leaves right after reset
   `UBXFB_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind ubx_frame_builder ubxfb_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
